@@ rtl/core/arca_pkg.sv @@
`timescale 1ns / 1ps

package arca_pkg;

    localparam int NUM_ROWS_DEF = 64;
    localparam int KEY_W        = 32;
    localparam int ROW_IDX_W    = 6;
    localparam int STATUS_W     = 3;
    localparam int CMD_DEPTH    = 2;
    localparam int RES_DEPTH    = 2;

    // request opcodes
    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_EOF    = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_HIT   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NEW   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOSRC = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EVICT = 3'd4;

    // classified command kinds between front and back
    localparam logic [1:0] CMD_LOOKUP = 2'd0;
    localparam logic [1:0] CMD_EVICT  = 2'd1;
    localparam logic [1:0] CMD_NOSRC  = 2'd2;

    typedef struct packed {
        logic             opcode;
        logic [KEY_W-1:0] source_key;
    } t_request;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [ROW_IDX_W-1:0] row_index;
    } t_result;

    typedef struct packed {
        logic [1:0]       kind;
        logic [KEY_W-1:0] key;
    } t_cmd;

endpackage

@@ rtl/core/arca_fifo.sv @@
`timescale 1ns / 1ps

module arca_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_rd,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr, n_wptr;
    logic [PTR_W-1:0] r_rptr, n_rptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             wr_en;
    logic             rd_en;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign wr_en   = i_wr && !o_full;
    assign rd_en   = i_rd && !o_empty;
    assign o_rdata = r_mem[r_rptr];

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (wr_en) begin
            n_wptr = (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (rd_en) begin
            n_rptr = (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (wr_en && !rd_en) begin
            n_count = r_count + 1'b1;
        end else if (rd_en && !wr_en) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

endmodule

@@ rtl/core/arca_front.sv @@
`timescale 1ns / 1ps

module arca_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  arca_pkg::t_request i_request,
    output logic              o_cmd_valid,
    output arca_pkg::t_cmd    o_cmd,
    input  logic              i_cmd_pop
);

    arca_pkg::t_cmd cmd_in;
    logic           cmd_empty;

    // classify on entry so the back end only sees three command kinds
    always_comb begin
        cmd_in.key = i_request.source_key;
        if (i_request.opcode == arca_pkg::OP_EOF) begin
            cmd_in.kind = arca_pkg::CMD_EVICT;
        end else if (i_request.source_key == '0) begin
            cmd_in.kind = arca_pkg::CMD_NOSRC;
        end else begin
            cmd_in.kind = arca_pkg::CMD_LOOKUP;
        end
    end

    arca_fifo #(
        .WIDTH ($bits(arca_pkg::t_cmd)),
        .DEPTH (arca_pkg::CMD_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (push),
        .i_wdata (cmd_in),
        .o_full  (full),
        .i_rd    (i_cmd_pop),
        .o_rdata (o_cmd),
        .o_empty (cmd_empty)
    );

    assign o_cmd_valid = !cmd_empty;

endmodule

@@ rtl/core/arca_back.sv @@
`timescale 1ns / 1ps

module arca_back #(
    parameter int NUM_ROWS = arca_pkg::NUM_ROWS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cmd_valid,
    input  arca_pkg::t_cmd   i_cmd,
    output logic             o_cmd_pop,
    input  logic             i_res_full,
    output logic             o_res_push,
    output arca_pkg::t_result o_res
);

    localparam int ROW_W = $clog2(NUM_ROWS);
    localparam int IDX_W = arca_pkg::ROW_IDX_W;

    localparam logic S_IDLE    = 1'b0;
    localparam logic S_RESOLVE = 1'b1;

    logic                      r_state, n_state;
    logic [NUM_ROWS-1:0]       r_taken, n_taken;
    logic [NUM_ROWS-1:0]       r_used, n_used;
    logic [NUM_ROWS-1:0]       r_match, n_match;
    logic [arca_pkg::KEY_W-1:0] r_key;
    logic [arca_pkg::KEY_W-1:0] r_row_key [NUM_ROWS];

    logic                      start;
    logic                      hit_any;
    logic                      free_any;
    logic [ROW_W-1:0]          hit_idx;
    logic [ROW_W-1:0]          free_idx;
    logic [ROW_W-1:0]          sel_idx;
    logic [ROW_W+IDX_W-1:0]    sel_wide;

    // one command at a time; a command is only taken when its result has room
    assign start     = (r_state == S_IDLE) && i_cmd_valid && !i_res_full;
    assign o_cmd_pop = start;

    // key compare against every taken row, registered for the resolve cycle
    always_comb begin
        for (int r = 0; r < NUM_ROWS; r++) begin
            n_match[r] = r_taken[r] && (r_row_key[r] == i_cmd.key);
        end
    end

    // lowest set bit wins
    always_comb begin
        hit_idx  = '0;
        free_idx = '0;
        for (int r = NUM_ROWS - 1; r >= 0; r--) begin
            if (r_match[r]) begin
                hit_idx = ROW_W'(r);
            end
            if (!r_taken[r]) begin
                free_idx = ROW_W'(r);
            end
        end
    end

    assign hit_any  = |r_match;
    assign free_any = !(&r_taken);
    assign sel_idx  = hit_any ? hit_idx : free_idx;
    assign sel_wide = {{IDX_W{1'b0}}, sel_idx};

    always_comb begin
        n_state          = r_state;
        n_taken          = r_taken;
        n_used           = r_used;
        o_res_push       = 1'b0;
        o_res.status     = arca_pkg::ST_EVICT;
        o_res.row_index  = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    case (i_cmd.kind)
                        arca_pkg::CMD_EVICT: begin
                            o_res_push   = 1'b1;
                            o_res.status = arca_pkg::ST_EVICT;
                            n_taken      = r_taken & r_used;
                            n_used       = '0;
                        end
                        arca_pkg::CMD_NOSRC: begin
                            o_res_push   = 1'b1;
                            o_res.status = arca_pkg::ST_NOSRC;
                        end
                        arca_pkg::CMD_LOOKUP: begin
                            n_state = S_RESOLVE;
                        end
                        default: begin
                            o_res_push   = 1'b1;
                            o_res.status = arca_pkg::ST_NOSRC;
                        end
                    endcase
                end
            end
            S_RESOLVE: begin
                n_state    = S_IDLE;
                o_res_push = 1'b1;
                if (hit_any) begin
                    o_res.status    = arca_pkg::ST_HIT;
                    o_res.row_index = sel_wide[IDX_W-1:0];
                    n_used[hit_idx] = 1'b1;
                end else if (free_any) begin
                    o_res.status      = arca_pkg::ST_NEW;
                    o_res.row_index   = sel_wide[IDX_W-1:0];
                    n_taken[free_idx] = 1'b1;
                    n_used[free_idx]  = 1'b1;
                end else begin
                    o_res.status = arca_pkg::ST_FULL;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_taken <= '0;
            r_used  <= '0;
        end else begin
            r_state <= n_state;
            r_taken <= n_taken;
            r_used  <= n_used;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_key   <= i_cmd.key;
            r_match <= n_match;
        end
        if (r_state == S_RESOLVE && !hit_any && free_any) begin
            r_row_key[free_idx] <= r_key;
        end
    end

endmodule

@@ rtl/core/atlas_row_cache_allocator.sv @@
`timescale 1ns / 1ps

// Atlas row cache allocator.
// Request side is a queue: drive i_request and raise push; the request is
// taken on a clock edge with push high and full low. Results come out as a
// queue too: while empty is low, o_result holds the oldest result, and it
// is removed on an edge with pop high. Every request gives exactly one
// result, in request order.
// In the back end a lookup gets a parallel key compare over all rows,
// registered, then first-hit / first-free pick and table update in the
// resolve state, during which no new request is taken; end-of-frame and
// zero-key requests are written to the result queue as they are taken.
// A two-entry request queue and a two-entry result queue sit either side of
// the engine. If the receiver stops popping, the result queue fills, the
// engine stalls, then the request queue fills and full goes high.
// Synchronous reset frees every row, clears the used bits and empties both
// queues; the block takes requests on the first cycle after reset.

module atlas_row_cache_allocator #(
    parameter int NUM_ROWS = arca_pkg::NUM_ROWS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  arca_pkg::t_request i_request,
    output logic               empty,
    input  logic               pop,
    output arca_pkg::t_result  o_result
);

    logic              cmd_valid;
    arca_pkg::t_cmd    cmd;
    logic              cmd_pop;
    logic              res_full;
    logic              res_push;
    arca_pkg::t_result res;

    arca_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_request   (i_request),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    arca_back #(
        .NUM_ROWS (NUM_ROWS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (res)
    );

    arca_fifo #(
        .WIDTH ($bits(arca_pkg::t_result)),
        .DEPTH (arca_pkg::RES_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (res_push),
        .i_wdata (res),
        .o_full  (res_full),
        .i_rd    (pop),
        .o_rdata (o_result),
        .o_empty (empty)
    );

endmodule

@@ rtl/core/arca_checker.sv @@
`timescale 1ns / 1ps

module arca_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              push,
    input logic              full,
    input logic              empty,
    input logic              pop,
    input arca_pkg::t_result i_result
);

    localparam int MAX_OUT = arca_pkg::CMD_DEPTH + arca_pkg::RES_DEPTH + 1;
    localparam int OUT_W   = $clog2(MAX_OUT + 1);

    logic             req_acc;
    logic             res_acc;
    logic [OUT_W-1:0] r_outstanding, n_outstanding;

    assign req_acc = push && !full;
    assign res_acc = pop && !empty;

    always_comb begin
        n_outstanding = r_outstanding;
        if (req_acc && !res_acc) begin
            n_outstanding = r_outstanding + 1'b1;
        end else if (res_acc && !req_acc) begin
            n_outstanding = r_outstanding - 1'b1;
        end
    end

    // requests accepted but not yet answered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outstanding <= '0;
        end else begin
            r_outstanding <= n_outstanding;
        end
    end

    // no result without a pending request
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_outstanding == '0) |-> empty)
        else $error("result shown with no request pending");

    // request side only backs up once the request queue is really holding items
    a_full_backlog: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> (r_outstanding >= OUT_W'(arca_pkg::CMD_DEPTH)))
        else $error("full raised with too few requests pending");

    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(i_result)))
        else $error("stalled result changed or vanished");

    a_row_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (i_result.status == arca_pkg::ST_FULL
                 || i_result.status == arca_pkg::ST_NOSRC
                 || i_result.status == arca_pkg::ST_EVICT))
        |-> (i_result.row_index == '0))
        else $error("row index set on a result without a row");

endmodule

bind atlas_row_cache_allocator arca_checker u_arca_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .push     (push),
    .full     (full),
    .empty    (empty),
    .pop      (pop),
    .i_result (o_result)
);
